/* src/stq_pkg.sv */
// Shared types, codes and helpers of the sorted timer queue.
package stq_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int TAG_WIDTH_DEF = 16;
	localparam int MAX_FIRE      = 16;
	localparam int FIRE_W        = $clog2(MAX_FIRE + 1);

	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_CANCEL = 2'd1,
		MODE_RUN    = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		KIND_STARTED   = 3'd0,
		KIND_CANCELLED = 3'd1,
		KIND_BAD       = 3'd2,
		KIND_EXPIRED   = 3'd3,
		KIND_NONE_DUE  = 3'd4,
		KIND_FIRST     = 3'd5,
		KIND_FULL      = 3'd6
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FREE,
		ST_INS_WALK,
		ST_INS_LINK,
		ST_INS_PREV,
		ST_CAN_WALK,
		ST_RUN,
		ST_QRY,
		ST_RESP
	} state_t;

	// a is at or after b on a wrapping 32-bit clock
	function automatic logic at_or_after(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] diff;
		diff = a - b;
		return !diff[31];
	endfunction

endpackage

/* src/stq_if.sv */
// Command and result channel interfaces of the sorted timer queue.
interface stq_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] now;
	logic [30:0] timeout;
	logic [15:0] timer_tag;
	logic [3:0]  cancel_handle;

	modport source (output valid, mode, now, timeout, timer_tag, cancel_handle, input ready);
	modport sink (input valid, mode, now, timeout, timer_tag, cancel_handle, output ready);
endinterface

interface stq_res_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [3:0]         handle;
	logic [15:0]        fired_tag;
	logic signed [31:0] remaining;
	logic               last;

	modport source (output valid, kind, handle, fired_tag, remaining, last, input ready);
	modport sink (input valid, kind, handle, fired_tag, remaining, last, output ready);
endinterface

/* src/sorted_timer_queue.sv */
// Sorted timer queue: up to DEPTH timers kept in a linked list ordered by deadline.
// One command item is taken at a time; cmd.ready is high only while the sequencer idles.
// The list lives in one memory with a single registered read port, walked one entry per
// cycle while nothing stalls it. Start scans for the lowest free slot, one slot a cycle,
// then walks the sorted list; cancel walks to its handle; run fires due timers from the
// head (at most 16 per item); query reads the head unless empty. A full result register
// lets the next command be taken while the final result of the last one waits; a run that
// fires several timers stalls while an earlier result is not yet taken. Deadlines compare
// wrap-safe: a timer is due when now minus its deadline, mod 2^32, is below 2^31.
module sorted_timer_queue #(
	parameter int DEPTH     = stq_pkg::DEPTH_DEF,
	parameter int TAG_WIDTH = stq_pkg::TAG_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	stq_cmd_if.sink  cmd,
	stq_res_if.source res
);
	import stq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// list storage
	logic [31:0]          dl_mem    [DEPTH];
	logic [TAG_WIDTH-1:0] label_mem [DEPTH];
	logic [IW-1:0]        link_mem  [DEPTH];
	logic [31:0]          dl_rd_q;
	logic [TAG_WIDTH-1:0] label_rd_q;
	logic [IW-1:0]        link_rd_q;

	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic          link_we;
	logic [IW-1:0] link_wa;
	logic [IW-1:0] link_wd;

	state_t            state_q, state_d;
	logic [DEPTH-1:0]  used_q, used_d;
	logic [CW-1:0]     count_q, count_d;
	logic [IW-1:0]     head_q, head_d;
	logic [FIRE_W-1:0] fired_q, fired_d;
	logic              prev_valid_q, prev_valid_d;
	logic              out_valid_q;

	logic [IW-1:0]        cur_q, cur_d;
	logic [IW-1:0]        prev_q, prev_d;
	logic [CW-1:0]        k_q, k_d;
	logic [IW-1:0]        slot_q, slot_d;
	logic [IW-1:0]        hslot_q, hslot_d;
	logic [31:0]          now_q, now_d;
	logic [31:0]          dl_q, dl_d;
	logic [TAG_WIDTH-1:0] tag_q, tag_d;

	kind_t              res_kind_q, res_kind_d;
	logic [3:0]         res_handle_q, res_handle_d;
	logic [15:0]        res_tag_q, res_tag_d;
	logic signed [31:0] res_rem_q, res_rem_d;

	kind_t              out_kind_q;
	logic [3:0]         out_handle_q;
	logic [15:0]        out_tag_q;
	logic signed [31:0] out_rem_q;
	logic               out_last_q;

	logic          can_emit;
	logic          emit;
	logic          emit_last;
	logic [IW-1:0] hslot_in;
	logic          hnd_ok;

	assign can_emit = !out_valid_q || res.ready;
	assign hslot_in = IW'(cmd.cancel_handle);
	assign hnd_ok   = ({28'd0, cmd.cancel_handle} < 32'(DEPTH)) && used_q[hslot_in];

	always_comb begin
		state_d      = state_q;
		used_d       = used_q;
		count_d      = count_q;
		head_d       = head_q;
		fired_d      = fired_q;
		prev_valid_d = prev_valid_q;
		cur_d        = cur_q;
		prev_d       = prev_q;
		k_d          = k_q;
		slot_d       = slot_q;
		hslot_d      = hslot_q;
		now_d        = now_q;
		dl_d         = dl_q;
		tag_d        = tag_q;
		res_kind_d   = res_kind_q;
		res_handle_d = res_handle_q;
		res_tag_d    = res_tag_q;
		res_rem_d    = res_rem_q;
		rd_addr      = cur_q;
		wr_en        = 1'b0;
		link_we      = 1'b0;
		link_wa      = prev_q;
		link_wd      = slot_q;
		emit         = 1'b0;
		emit_last    = 1'b0;
		cmd.ready    = (state_q == ST_IDLE);

		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					now_d        = cmd.now;
					dl_d         = cmd.now + {1'b0, cmd.timeout};
					tag_d        = TAG_WIDTH'(cmd.timer_tag);
					hslot_d      = hslot_in;
					cur_d        = head_q;
					rd_addr      = head_q;
					prev_valid_d = 1'b0;
					k_d          = '0;
					slot_d       = '0;
					fired_d      = '0;
					res_handle_d = '0;
					res_tag_d    = '0;
					res_rem_d    = '0;
					case (cmd.mode)
						MODE_START: begin
							if (count_q == CW'(DEPTH)) begin
								res_kind_d = KIND_FULL;
								state_d    = ST_RESP;
							end else begin
								state_d = ST_FREE;
							end
						end
						MODE_CANCEL: begin
							if (!hnd_ok) begin
								res_kind_d   = KIND_BAD;
								res_handle_d = cmd.cancel_handle;
								state_d      = ST_RESP;
							end else begin
								state_d = ST_CAN_WALK;
							end
						end
						MODE_RUN: begin
							state_d = ST_RUN;
						end
						default: begin
							res_kind_d = KIND_FIRST;
							if (count_q == '0) begin
								res_rem_d = '1;
								state_d   = ST_RESP;
							end else begin
								state_d = ST_QRY;
							end
						end
					endcase
				end
			end
			ST_FREE: begin
				// scan for the lowest free slot, then prime the walk at the head
				if (!used_q[slot_q]) begin
					cur_d   = head_q;
					rd_addr = head_q;
					state_d = ST_INS_WALK;
				end else begin
					slot_d = slot_q + 1'b1;
				end
			end
			ST_INS_WALK: begin
				if (k_q == count_q || !at_or_after(dl_q, dl_rd_q)) begin
					state_d = ST_INS_LINK;
				end else begin
					prev_d       = cur_q;
					prev_valid_d = 1'b1;
					cur_d        = link_rd_q;
					rd_addr      = link_rd_q;
					k_d          = k_q + 1'b1;
				end
			end
			ST_INS_LINK: begin
				// cur holds the successor of the new entry
				wr_en          = 1'b1;
				link_we        = 1'b1;
				link_wa        = slot_q;
				link_wd        = cur_q;
				used_d[slot_q] = 1'b1;
				count_d        = count_q + 1'b1;
				res_kind_d     = KIND_STARTED;
				res_handle_d   = 4'(slot_q);
				if (prev_valid_q) begin
					state_d = ST_INS_PREV;
				end else begin
					head_d  = slot_q;
					state_d = ST_RESP;
				end
			end
			ST_INS_PREV: begin
				link_we = 1'b1;
				link_wa = prev_q;
				link_wd = slot_q;
				state_d = ST_RESP;
			end
			ST_CAN_WALK: begin
				if (cur_q == hslot_q) begin
					// unlink: predecessor or head takes the successor
					if (prev_valid_q) begin
						link_we = 1'b1;
						link_wa = prev_q;
						link_wd = link_rd_q;
					end else begin
						head_d = link_rd_q;
					end
					used_d[hslot_q] = 1'b0;
					count_d         = count_q - 1'b1;
					res_kind_d      = KIND_CANCELLED;
					res_handle_d    = 4'(hslot_q);
					state_d         = ST_RESP;
				end else begin
					prev_d       = cur_q;
					prev_valid_d = 1'b1;
					cur_d        = link_rd_q;
					rd_addr      = link_rd_q;
				end
			end
			ST_RUN: begin
				if (count_q != '0 && fired_q != FIRE_W'(MAX_FIRE)
						&& at_or_after(now_q, dl_rd_q)) begin
					// hold the expiry in res until the next one shows it is not the last
					if (fired_q == '0 || can_emit) begin
						emit          = (fired_q != '0);
						res_kind_d    = KIND_EXPIRED;
						res_handle_d  = 4'(cur_q);
						res_tag_d     = 16'(label_rd_q);
						res_rem_d     = '0;
						head_d        = link_rd_q;
						cur_d         = link_rd_q;
						rd_addr       = link_rd_q;
						used_d[cur_q] = 1'b0;
						count_d       = count_q - 1'b1;
						fired_d       = fired_q + 1'b1;
					end
				end else begin
					if (fired_q == '0) begin
						res_kind_d   = KIND_NONE_DUE;
						res_handle_d = '0;
						res_tag_d    = '0;
						res_rem_d    = '0;
					end
					state_d = ST_RESP;
				end
			end
			ST_QRY: begin
				res_rem_d = at_or_after(now_q, dl_rd_q) ? '0 : dl_rd_q - now_q;
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			dl_mem[slot_q]    <= dl_q;
			label_mem[slot_q] <= tag_q;
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		dl_rd_q    <= dl_mem[rd_addr];
		label_rd_q <= label_mem[rd_addr];
		link_rd_q  <= link_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= '0;
			count_q      <= '0;
			head_q       <= '0;
			fired_q      <= '0;
			prev_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			used_q       <= used_d;
			count_q      <= count_d;
			head_q       <= head_d;
			fired_q      <= fired_d;
			prev_valid_q <= prev_valid_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q        <= cur_d;
		prev_q       <= prev_d;
		k_q          <= k_d;
		slot_q       <= slot_d;
		hslot_q      <= hslot_d;
		now_q        <= now_d;
		dl_q         <= dl_d;
		tag_q        <= tag_d;
		res_kind_q   <= res_kind_d;
		res_handle_q <= res_handle_d;
		res_tag_q    <= res_tag_d;
		res_rem_q    <= res_rem_d;
		if (emit) begin
			out_kind_q   <= res_kind_q;
			out_handle_q <= res_handle_q;
			out_tag_q    <= res_tag_q;
			out_rem_q    <= res_rem_q;
			out_last_q   <= emit_last;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.kind      = out_kind_q;
	assign res.handle    = out_handle_q;
	assign res.fired_tag = out_tag_q;
	assign res.remaining = out_rem_q;
	assign res.last      = out_last_q;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the sorted timer queue: directed table, then random phases.
module tb_top;
	import stq_pkg::*;

	localparam int SLOTS     = DEPTH_DEF;
	localparam int LIMIT     = 500000;
	localparam int HOLD_LEN  = 300;
	localparam int PHASE_LEN = 37;

	typedef enum int {PH_NONE, PH_SRC, PH_SINK, PH_BOTH} idle_t;

	typedef struct packed {
		mode_t       mode;
		logic [31:0] now;
		logic [30:0] timeout;
		logic [15:0] tag;
		logic [3:0]  hnd;
	} cmd_t;

	typedef struct packed {
		kind_t              kind;
		logic [3:0]         handle;
		logic [15:0]        tag;
		logic signed [31:0] rem;
		logic               last;
	} report_t;

	typedef struct {
		cmd_t    c;
		int      reps;
		bit      typed;
		report_t r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	stq_cmd_if cmd();
	stq_res_if res();

	sorted_timer_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	always #1 clk = ~clk;

	// timer list as the block should hold it
	bit [31:0] tq_deadline [SLOTS];
	bit [15:0] tq_tag [SLOTS];
	bit        tq_used [SLOTS];
	bit [3:0]  tq_next [SLOTS];
	bit [3:0]  tq_head;

	report_t   fresh_reports[$];
	report_t   awaited_reports[$];
	row_t      directed[$];

	idle_t       idle_phase = PH_NONE;
	bit [31:0]   clk_now;
	int          err_cnt    = 0;
	int          cycles     = 0;
	int          hold_req   = 0;
	int          hold_seen  = 0;
	int          stall_left = 0;

	function automatic bit reached(bit [31:0] t, bit [31:0] mark);
		bit [31:0] d;
		d = t - mark;
		return d < 32'h8000_0000;
	endfunction

	function automatic report_t mk(kind_t k, logic [3:0] h, logic [15:0] g,
			logic signed [31:0] r, logic l);
		report_t x;
		x.kind   = k;
		x.handle = h;
		x.tag    = g;
		x.rem    = r;
		x.last   = l;
		return x;
	endfunction

	// advance the timer list by one command and collect the results it causes
	function automatic void apply_timer_cmd(cmd_t c);
		int        n;
		int        slot;
		int        prev;
		int        k;
		bit [3:0]  cur;
		bit [3:0]  h;
		bit [31:0] dl;
		report_t   r;
		n = 0;
		foreach (tq_used[i]) n += int'(tq_used[i]);
		fresh_reports.delete();
		case (c.mode)
			MODE_START: begin
				slot = -1;
				for (int i = 0; i < SLOTS; i++)
					if (!tq_used[i] && slot < 0) slot = i;
				if (slot < 0) begin
					fresh_reports.push_back(mk(KIND_FULL, 0, 0, 0, 1));
				end else begin
					dl = c.now + c.timeout;
					prev = -1;
					cur = tq_head;
					// equal deadlines keep arrival order
					for (int i = 0; i < n; i++) begin
						if (!reached(dl, tq_deadline[cur])) break;
						prev = int'(cur);
						cur = tq_next[cur];
					end
					tq_deadline[slot] = dl;
					tq_tag[slot] = c.tag;
					tq_used[slot] = 1'b1;
					if (prev < 0) begin
						tq_next[slot] = tq_head;
						tq_head = slot[3:0];
					end else begin
						tq_next[slot] = tq_next[prev];
						tq_next[prev] = slot[3:0];
					end
					fresh_reports.push_back(mk(KIND_STARTED, slot[3:0], 0, 0, 1));
				end
			end
			MODE_CANCEL: begin
				if (!tq_used[c.hnd]) begin
					fresh_reports.push_back(mk(KIND_BAD, c.hnd, 0, 0, 1));
				end else begin
					prev = -1;
					cur = tq_head;
					for (int i = 0; i < n; i++) begin
						if (cur == c.hnd) break;
						prev = int'(cur);
						cur = tq_next[cur];
					end
					if (prev < 0) tq_head = tq_next[c.hnd];
					else tq_next[prev] = tq_next[c.hnd];
					tq_used[c.hnd] = 1'b0;
					fresh_reports.push_back(mk(KIND_CANCELLED, c.hnd, 0, 0, 1));
				end
			end
			MODE_RUN: begin
				k = 0;
				while (n > 0 && k < MAX_FIRE) begin
					h = tq_head;
					if (!reached(c.now, tq_deadline[h])) break;
					fresh_reports.push_back(mk(KIND_EXPIRED, h, tq_tag[h], 0, 0));
					k++;
					tq_head = tq_next[h];
					tq_used[h] = 1'b0;
					n--;
				end
				if (k == 0) begin
					fresh_reports.push_back(mk(KIND_NONE_DUE, 0, 0, 0, 1));
				end else begin
					r = fresh_reports.pop_back();
					r.last = 1'b1;
					fresh_reports.push_back(r);
				end
			end
			default: begin
				if (n == 0)
					fresh_reports.push_back(mk(KIND_FIRST, 0, 0, -1, 1));
				else if (reached(c.now, tq_deadline[tq_head]))
					fresh_reports.push_back(mk(KIND_FIRST, 0, 0, 0, 1));
				else
					fresh_reports.push_back(mk(KIND_FIRST, 0, 0,
						tq_deadline[tq_head] - c.now, 1));
			end
		endcase
	endfunction

	task automatic add_row(mode_t m, logic [31:0] t, logic [30:0] to, logic [15:0] g,
			logic [3:0] h, int reps, bit typed, kind_t k, logic [3:0] eh,
			logic signed [31:0] er);
		row_t w;
		w.c.mode    = m;
		w.c.now     = t;
		w.c.timeout = to;
		w.c.tag     = g;
		w.c.hnd     = h;
		w.reps      = reps;
		w.typed     = typed;
		w.r         = mk(k, eh, 0, er, 1);
		directed.push_back(w);
	endtask

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int   pick;
		int   r;
		int   cand[$];
		c.now     = $urandom;
		c.timeout = 31'($urandom);
		c.tag     = 16'($urandom);
		c.hnd     = 4'($urandom);
		clk_now += $urandom_range(12);
		if ($urandom_range(99) >= 5) c.now = clk_now;
		pick = $urandom_range(99);
		if (pick < 40) begin
			c.mode = MODE_START;
			r = $urandom_range(99);
			if (r < 80) c.timeout = 31'($urandom_range(200));
			else if (r < 85) c.timeout = '1;
			else if (r < 90) c.timeout = '0;
		end else if (pick < 60) begin
			c.mode = MODE_CANCEL;
			foreach (tq_used[i]) if (tq_used[i]) cand.push_back(i);
			if (cand.size() > 0 && $urandom_range(3) != 0)
				c.hnd = 4'(cand[$urandom_range(cand.size() - 1)]);
		end else if (pick < 85) begin
			c.mode = MODE_RUN;
		end else begin
			c.mode = MODE_QUERY;
		end
		return c;
	endfunction

	task automatic offer(input cmd_t c, input bit typed, input report_t typed_res);
		int pct;
		pct = (idle_phase == PH_SRC) ? 69 : (idle_phase == PH_BOTH) ? 16 : 0;
		while ($urandom_range(99) < pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid         <= 1'b1;
		cmd.mode          <= c.mode;
		cmd.now           <= c.now;
		cmd.timeout       <= c.timeout;
		cmd.timer_tag     <= c.tag;
		cmd.cancel_handle <= c.hnd;
		@(posedge clk);
		while (cmd.ready !== 1'b1) @(posedge clk);
		apply_timer_cmd(c);
		if (typed) awaited_reports.push_back(typed_res);
		else foreach (fresh_reports[i]) awaited_reports.push_back(fresh_reports[i]);
	endtask

	// hold the input until every awaited result is back
	task automatic drain();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (awaited_reports.size() != 0) @(posedge clk);
	endtask

	initial begin
		cmd_t    c;
		report_t blank;
		arst_n            = 1'b0;
		cmd.valid         = 1'b0;
		cmd.mode          = '0;
		cmd.now           = '0;
		cmd.timeout       = '0;
		cmd.timer_tag     = '0;
		cmd.cancel_handle = '0;
		blank             = '0;
		foreach (tq_used[i]) tq_used[i] = 1'b0;
		tq_head = '0;

		add_row(MODE_QUERY,  32'h0,         31'h0,         16'h0,    4'd0,  1, 1,
			KIND_FIRST, 0, -1);
		add_row(MODE_RUN,    32'h0,         31'h0,         16'h0,    4'd0,  1, 1,
			KIND_NONE_DUE, 0, 0);
		add_row(MODE_CANCEL, 32'h0,         31'h0,         16'h0,    4'd0,  1, 1,
			KIND_BAD, 4'd0, 0);
		add_row(MODE_CANCEL, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 4'd15, 1, 1,
			KIND_BAD, 4'd15, 0);
		add_row(MODE_START,  32'h0,         31'h0,         16'hFFFF, 4'd0,  1, 1,
			KIND_STARTED, 4'd0, 0);
		add_row(MODE_START,  32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'h0,    4'd15, 1, 1,
			KIND_STARTED, 4'd1, 0);
		add_row(MODE_START,  32'h0,         31'h0,         16'h1234, 4'd0,  1, 1,
			KIND_STARTED, 4'd2, 0);
		add_row(MODE_QUERY,  32'h0,         31'h0,         16'h0,    4'd0,  1, 1,
			KIND_FIRST, 0, 0);
		// just short of the wrap, the head deadline is still ahead
		add_row(MODE_RUN,    32'hFFFF_FFFF, 31'h0,         16'h0,    4'd0,  1, 1,
			KIND_NONE_DUE, 0, 0);
		add_row(MODE_QUERY,  32'hFFFF_FFFE, 31'h0,         16'h0,    4'd0,  1, 1,
			KIND_FIRST, 0, 2);
		add_row(MODE_CANCEL, 32'h0,         31'h0,         16'h0,    4'd1,  1, 1,
			KIND_CANCELLED, 4'd1, 0);
		add_row(MODE_CANCEL, 32'h0,         31'h0,         16'h0,    4'd1,  1, 1,
			KIND_BAD, 4'd1, 0);
		// fill every free slot with equal deadlines
		add_row(MODE_START,  32'h100,       31'h10,        16'hA500, 4'd0, 14, 0,
			KIND_STARTED, 0, 0);
		add_row(MODE_START,  32'h100,       31'h10,        16'h5A5A, 4'd0,  1, 1,
			KIND_FULL, 0, 0);
		add_row(MODE_CANCEL, 32'h0,         31'h0,         16'h0,    4'd7,  1, 1,
			KIND_CANCELLED, 4'd7, 0);
		add_row(MODE_START,  32'h100,       31'h10,        16'h0F0F, 4'd0,  1, 1,
			KIND_STARTED, 4'd7, 0);
		// every timer due: a full burst of expiries
		add_row(MODE_RUN,    32'h7FFF_FFFF, 31'h0,         16'h0,    4'd0,  1, 0,
			KIND_EXPIRED, 0, 0);
		add_row(MODE_QUERY,  32'h5,         31'h0,         16'h0,    4'd0,  1, 1,
			KIND_FIRST, 0, -1);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			for (int j = 0; j < directed[i].reps; j++) begin
				c = directed[i].c;
				c.tag = c.tag ^ 16'(j);
				offer(c, directed[i].typed, directed[i].r);
			end
		end
		drain();

		clk_now = 32'hFFFF_FF00;
		for (int p = 0; p < 4; p++) begin
			idle_phase = idle_t'(p);
			// long receiver hold-off while commands keep coming
			if (p == 0) hold_req++;
			for (int j = 0; j < PHASE_LEN; j++) begin
				c = rand_cmd();
				offer(c, 1'b0, blank);
			end
			drain();
		end

		repeat (50) @(posedge clk);
		if (err_cnt == 0)
			$display("[sorted_timer_queue] OK");
		else
			$display("[sorted_timer_queue] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		report_t e;
		int      pct;
		if (res.valid === 1'b1 && res.ready === 1'b1) begin
			if (awaited_reports.size() == 0) begin
				$error("unexpected result: kind %0d handle %0d", res.kind, res.handle);
				err_cnt++;
			end else begin
				e = awaited_reports.pop_front();
				if (res.kind !== e.kind) begin
					$error("kind: expected %0d, got %0d", e.kind, res.kind);
					err_cnt++;
				end
				if (res.handle !== e.handle) begin
					$error("handle: expected %0d, got %0d", e.handle, res.handle);
					err_cnt++;
				end
				if (res.fired_tag !== e.tag) begin
					$error("fired_tag: expected %0h, got %0h", e.tag, res.fired_tag);
					err_cnt++;
				end
				if (res.remaining !== e.rem) begin
					$error("remaining: expected %0d, got %0d", e.rem, res.remaining);
					err_cnt++;
				end
				if (res.last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, res.last);
					err_cnt++;
				end
			end
		end
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			stall_left = HOLD_LEN;
		end
		pct = (idle_phase == PH_SINK) ? 69 : (idle_phase == PH_BOTH) ? 16 : 0;
		if (stall_left > 0) begin
			stall_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("[sorted_timer_queue] ERROR");
			$finish;
		end
	end

endmodule

/* files.f */
src/stq_pkg.sv
src/stq_if.sv
src/sorted_timer_queue.sv
tb/sv/tb_top.sv
